/* rtl/core/etpe_pkg.sv */
// Package for the ESC throttle pulse encoder: field widths, protocol codes,
// scaling constants and the DShot tick tables.
// Depends on nothing; every other file of the block uses it.
package etpe_pkg;

    // Field widths.
    localparam int THROTTLE_W = 11;
    localparam int TICK_W     = 15;
    localparam int SLOT_W     = 4;
    localparam int PROTO_W    = 3;
    localparam int CRC_W      = 4;
    localparam int FRAME_W    = 16;

    // Protocol codes held in the configuration register.
    typedef enum logic [PROTO_W-1:0] {
        PROTO_PWM        = 3'd0,
        PROTO_ONESHOT125 = 3'd1,
        PROTO_ONESHOT42  = 3'd2,
        PROTO_MULTISHOT  = 3'd3,
        PROTO_DSHOT150   = 3'd4,
        PROTO_DSHOT300   = 3'd5,
        PROTO_DSHOT600   = 3'd6,
        PROTO_DSHOT1200  = 3'd7
    } protocol_t;

    // Oneshot125 gain.
    localparam logic [TICK_W-1:0] OS125_GAIN = 15'd10;

    // Oneshot42: floor(t*336/100) = floor(t*84/25), done as a multiply by
    // 84 * ceil(2^22/25) and a shift; exact for every 11-bit throttle.
    localparam int                OS42_SHIFT  = 22;
    localparam int                OS42_PROD_W = 35;
    localparam logic [23:0]       OS42_MULT   = 24'd14092932;

    // Multishot: floor(d*16/10) = floor(d*8/5), done as a multiply by
    // 8 * ceil(2^16/5) and a shift; exact for every d below 2048.
    localparam int                MS_SHIFT  = 16;
    localparam int                MS_PROD_W = 28;
    localparam logic [16:0]       MS_MULT   = 17'd104864;
    localparam logic [THROTTLE_W-1:0] MS_FLOOR  = 11'd1000;
    localparam logic [TICK_W-1:0]     MS_OFFSET = 15'd400;

    // Last slot index of a DShot frame.
    localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd15;

    // Pulse status shown with each word of the output register.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic              fast_clock;
        logic              last;
    } pulse_t;

    // High time of a DShot bit, in clock ticks.
    function automatic logic [TICK_W-1:0] dshot_high(protocol_t proto, logic one);
        logic [TICK_W-1:0] ticks;
        begin
            case (proto)
                PROTO_DSHOT150:  ticks = one ? 15'd400 : 15'd200;
                PROTO_DSHOT300:  ticks = one ? 15'd200 : 15'd100;
                PROTO_DSHOT600:  ticks = one ? 15'd98  : 15'd48;
                PROTO_DSHOT1200: ticks = one ? 15'd50  : 15'd25;
                default:         ticks = '0;
            endcase
            return ticks;
        end
    endfunction

    // Low time of a DShot bit, in clock ticks.
    function automatic logic [TICK_W-1:0] dshot_low(protocol_t proto, logic one);
        logic [TICK_W-1:0] ticks;
        begin
            case (proto)
                PROTO_DSHOT150:  ticks = one ? 15'd135 : 15'd335;
                PROTO_DSHOT300:  ticks = one ? 15'd66  : 15'd166;
                PROTO_DSHOT600:  ticks = one ? 15'd34  : 15'd84;
                PROTO_DSHOT1200: ticks = one ? 15'd17  : 15'd42;
                default:         ticks = '0;
            endcase
            return ticks;
        end
    endfunction

endpackage

/* rtl/core/etpe_if.sv */
// Channel interfaces of the ESC throttle pulse encoder: command words in,
// pulse words out, and the protocol register write channel.
// Depends on etpe_pkg for the field widths.

// Command channel: one throttle word per handshake.
interface etpe_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [etpe_pkg::THROTTLE_W-1:0] throttle;
    logic                            telemetry_request;

    modport source (output valid, output throttle, output telemetry_request, input ready);
    modport sink   (input valid, input throttle, input telemetry_request, output ready);
endinterface

// Pulse channel: one pulse slot per handshake.
interface etpe_pulse_if;
    logic                          valid;
    logic                          ready;
    logic [etpe_pkg::SLOT_W-1:0]   slot;
    logic [etpe_pkg::TICK_W-1:0]   high_ticks;
    logic [etpe_pkg::TICK_W-1:0]   low_ticks;
    logic                          fast_clock;
    logic                          last;

    modport source (output valid, output slot, output high_ticks, output low_ticks,
                    output fast_clock, output last, input ready);
    modport sink   (input valid, input slot, input high_ticks, input low_ticks,
                    input fast_clock, input last, output ready);
endinterface

// Configuration channel: writes the protocol register.
interface etpe_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [etpe_pkg::PROTO_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/esc_throttle_pulse_encoder.sv */
// Top level of the ESC throttle pulse encoder: input register, scaling and
// frame build, slot serialiser and output register.
// Depends on etpe_pkg and the channel interfaces in etpe_if.sv.

// Each command word (throttle and telemetry request) becomes pulse slots in
// the protocol held in the protocol register (reset: PWM). An analog mode
// (PWM, Oneshot125, Oneshot42, Multishot) gives one slot with the scaled
// throttle as high time and no low time; a DShot mode gives sixteen slots,
// most significant frame bit first, with the speed's fixed tick counts.
// A word passes through the input register and the slot serialiser to the
// output register.
// Analog words flow at one per cycle while the output side does not stall; a
// DShot word occupies the slot serialiser for all sixteen slots, one slot per
// cycle when the output is not stalled, and the next word enters the serialiser
// only as its last slot is emitted. The protocol register is written through
// the cfg channel, which is always ready, and should only be written while no word is in flight.
module esc_throttle_pulse_encoder (
    input  logic                clk,
    input  logic                rst_n,
    etpe_cfg_if.sink            cfg,
    etpe_cmd_if.sink            cmd,
    etpe_pulse_if.source        pulse
);

    // Protocol register.
    etpe_pkg::protocol_t protocol_reg;

    // Input register.
    logic                            in_valid_reg;
    logic [etpe_pkg::THROTTLE_W-1:0] in_throttle_reg;
    logic                            in_telemetry_reg;

    // Slot serialiser.
    logic                            work_valid_reg;
    logic                            work_dshot_reg;
    etpe_pkg::protocol_t             work_proto_reg;
    logic [etpe_pkg::FRAME_W-1:0]    work_frame_reg;
    logic [etpe_pkg::FRAME_W-1:0]    work_frame_next;
    logic [etpe_pkg::SLOT_W-1:0]     work_cnt_reg;
    logic [etpe_pkg::SLOT_W-1:0]     work_cnt_next;
    logic [etpe_pkg::TICK_W-1:0]     work_hi_reg;
    logic [etpe_pkg::TICK_W-1:0]     work_hi_next;

    // Output register.
    logic                            out_valid_reg;
    etpe_pkg::pulse_t                out_reg;
    etpe_pkg::pulse_t                out_next;

    // Handshake terms.
    logic out_free;
    logic emit;
    logic work_last;
    logic work_done;
    logic work_free;
    logic load_work;
    logic in_free;

    // Scaling terms.
    logic [etpe_pkg::OS42_PROD_W-1:0] os42_prod;
    logic [etpe_pkg::MS_PROD_W-1:0]   ms_prod;
    logic [etpe_pkg::THROTTLE_W-1:0]  ms_delta;
    logic [etpe_pkg::TICK_W-1:0]      os125_ticks;
    logic [etpe_pkg::TICK_W-1:0]      os42_ticks;
    logic [etpe_pkg::TICK_W-1:0]      ms_ticks;
    logic [etpe_pkg::FRAME_W-5:0]     frame_head;
    logic [etpe_pkg::CRC_W-1:0]       frame_crc;

    // The protocol register always takes a write at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_reg <= etpe_pkg::PROTO_PWM;
        end
        else if (cfg.valid)
        begin
            protocol_reg <= etpe_pkg::protocol_t'(cfg.data);
        end
    end

    // Handshake chain from the output back to the command channel.
    assign out_free  = !out_valid_reg || pulse.ready;
    assign emit      = work_valid_reg && out_free;
    assign work_last = !work_dshot_reg || (work_cnt_reg == etpe_pkg::SLOT_LAST);
    assign work_done = emit && work_last;
    assign work_free = !work_valid_reg || work_done;
    assign load_work = in_valid_reg && work_free;
    assign in_free   = !in_valid_reg || load_work;
    assign cmd.ready = in_free;

    // Input register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    // Input register: payload.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && in_free)
        begin
            in_throttle_reg  <= cmd.throttle;
            in_telemetry_reg <= cmd.telemetry_request;
        end
    end

    // Analog scaling. Oneshot125 is a constant multiply; Oneshot42 and Multishot are a constant multiply and a shift.
    always_comb
    begin
        os125_ticks = etpe_pkg::TICK_W'(in_throttle_reg) * etpe_pkg::OS125_GAIN;
        os42_prod   = etpe_pkg::OS42_PROD_W'(in_throttle_reg)
                    * etpe_pkg::OS42_PROD_W'(etpe_pkg::OS42_MULT);
        os42_ticks  = etpe_pkg::TICK_W'(os42_prod[etpe_pkg::OS42_PROD_W-1:etpe_pkg::OS42_SHIFT]);
        // Multishot saturates below the floor value.
        ms_delta    = (in_throttle_reg < etpe_pkg::MS_FLOOR) ? '0
                    : in_throttle_reg - etpe_pkg::MS_FLOOR;
        ms_prod     = etpe_pkg::MS_PROD_W'(ms_delta) * etpe_pkg::MS_PROD_W'(etpe_pkg::MS_MULT);
        ms_ticks    = etpe_pkg::TICK_W'(ms_prod[etpe_pkg::MS_PROD_W-1:etpe_pkg::MS_SHIFT])
                    + etpe_pkg::MS_OFFSET;
    end

    // High time of the single analog slot.
    always_comb
    begin
        case (protocol_reg)
            etpe_pkg::PROTO_PWM:        work_hi_next = etpe_pkg::TICK_W'(in_throttle_reg);
            etpe_pkg::PROTO_ONESHOT125: work_hi_next = os125_ticks;
            etpe_pkg::PROTO_ONESHOT42:  work_hi_next = os42_ticks;
            etpe_pkg::PROTO_MULTISHOT:  work_hi_next = ms_ticks;
            default:                    work_hi_next = '0;
        endcase
    end

    // DShot frame: throttle, telemetry bit, XOR of the three nibbles.
    always_comb
    begin
        frame_head = {in_throttle_reg, in_telemetry_reg};
        frame_crc  = frame_head[3:0] ^ frame_head[7:4] ^ frame_head[11:8];
    end

    // Serialiser next state: load a new word, or step to the next slot.
    always_comb
    begin
        work_frame_next = work_frame_reg;
        work_cnt_next   = work_cnt_reg;
        if (load_work)
        begin
            work_frame_next = {frame_head, frame_crc};
            work_cnt_next   = '0;
        end
        else if (emit && !work_last)
        begin
            work_frame_next = {work_frame_reg[etpe_pkg::FRAME_W-2:0], 1'b0};
            work_cnt_next   = work_cnt_reg + 1'b1;
        end
    end

    // Serialiser: control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            work_cnt_reg   <= '0;
        end
        else
        begin
            if (work_free)
            begin
                work_valid_reg <= in_valid_reg;
            end
            work_cnt_reg <= work_cnt_next;
        end
    end

    // Serialiser: payload.
    always_ff @(posedge clk)
    begin
        work_frame_reg <= work_frame_next;
        if (load_work)
        begin
            work_proto_reg <= protocol_reg;
            work_dshot_reg <= protocol_reg[etpe_pkg::PROTO_W-1];
            work_hi_reg    <= work_hi_next;
        end
    end

    // Current slot word.
    always_comb
    begin
        out_next.slot       = work_cnt_reg;
        out_next.fast_clock = (work_proto_reg != etpe_pkg::PROTO_PWM);
        out_next.last       = work_last;
        if (work_dshot_reg)
        begin
            out_next.high_ticks = etpe_pkg::dshot_high(work_proto_reg,
                                                       work_frame_reg[etpe_pkg::FRAME_W-1]);
            out_next.low_ticks  = etpe_pkg::dshot_low(work_proto_reg,
                                                      work_frame_reg[etpe_pkg::FRAME_W-1]);
        end
        else
        begin
            out_next.high_ticks = work_hi_reg;
            out_next.low_ticks  = '0;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= work_valid_reg;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign pulse.valid      = out_valid_reg;
    assign pulse.slot       = out_reg.slot;
    assign pulse.high_ticks = out_reg.high_ticks;
    assign pulse.low_ticks  = out_reg.low_ticks;
    assign pulse.fast_clock = out_reg.fast_clock;
    assign pulse.last       = out_reg.last;

`ifndef SYNTH
    // A PWM word is always a single slot, the first and the last.
    a_pwm_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.fast_clock |-> out_reg.last && (out_reg.slot == '0))
        else $error("PWM word is not a single last slot");

    // A DShot slot that is not the last keeps the serialiser busy.
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !work_last |=> work_valid_reg)
        else $error("serialiser dropped a DShot frame early");

    // Slots of a frame are numbered one after another.
    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !work_last |=> work_cnt_reg == $past(work_cnt_reg) + 1'b1)
        else $error("DShot slot index skipped");

    // A held input word is not lost while the serialiser is busy.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !load_work |=> in_valid_reg && $stable(in_throttle_reg))
        else $error("input word lost while serialiser busy");
`endif

endmodule

/* test/esc_throttle_pulse_encoder_checker.sv */
// Checker for the ESC throttle pulse encoder: watches the protocol, command
// and pulse channels, predicts every pulse word and compares.
// Depends on etpe_pkg and the channel interfaces in etpe_if.sv.
`timescale 1ns / 100ps

module esc_throttle_pulse_encoder_checker (
    input  logic    clk,
    input  logic    rst_n,
    etpe_cfg_if     cfg,
    etpe_cmd_if     cmd,
    etpe_pulse_if   pulse,
    output int      errors,
    output int      outstanding
);
    import etpe_pkg::*;

    // DShot tick counts per speed, indexed from DShot150 upwards.
    localparam logic [TICK_W-1:0] ONE_HIGH [4]  = '{15'd400, 15'd200, 15'd98, 15'd50};
    localparam logic [TICK_W-1:0] ONE_LOW [4]   = '{15'd135, 15'd66, 15'd34, 15'd17};
    localparam logic [TICK_W-1:0] ZERO_HIGH [4] = '{15'd200, 15'd100, 15'd48, 15'd25};
    localparam logic [TICK_W-1:0] ZERO_LOW [4]  = '{15'd335, 15'd166, 15'd84, 15'd42};

    protocol_t mode;
    pulse_t    expected_pulses[$];

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string msg);
        begin
            errors++;
            $display("%0t ns: pulse mismatch: %s", $time, msg);
        end
    endtask

    // Works out the pulse words that one command word gives in the given mode.
    function automatic void encode_throttle(input protocol_t proto,
                                            input logic [THROTTLE_W-1:0] throttle,
                                            input logic telemetry);
        pulse_t               w;
        int unsigned          t;
        int unsigned          scaled;
        int                   speed;
        logic [11:0]          f12;
        logic [FRAME_W-1:0]   frame;
        begin
            t = throttle;
            if (proto < PROTO_DSHOT150)
            begin
                // Analog modes: a single slot with the scaled throttle as high time.
                case (proto)
                    PROTO_PWM:        scaled = t;
                    PROTO_ONESHOT125: scaled = t * 10;
                    PROTO_ONESHOT42:  scaled = (t * 336) / 100;
                    default:
                    begin
                        // Multishot saturates below 1000.
                        if (t < 1000)
                            t = 1000;
                        scaled = ((t - 1000) * 16) / 10 + 400;
                    end
                endcase
                w.slot       = '0;
                w.high_ticks = TICK_W'(scaled);
                w.low_ticks  = '0;
                w.fast_clock = (proto != PROTO_PWM);
                w.last       = 1'b1;
                expected_pulses.push_back(w);
            end
            else
            begin
                // DShot: throttle, telemetry bit and nibble checksum, MSB first.
                speed = int'(proto) - int'(PROTO_DSHOT150);
                f12   = {throttle, telemetry};
                frame = {f12, f12[11:8] ^ f12[7:4] ^ f12[3:0]};
                for (int i = 0; i < FRAME_W; i++)
                begin
                    w.slot       = SLOT_W'(i);
                    w.high_ticks = frame[FRAME_W-1-i] ? ONE_HIGH[speed] : ZERO_HIGH[speed];
                    w.low_ticks  = frame[FRAME_W-1-i] ? ONE_LOW[speed] : ZERO_LOW[speed];
                    w.fast_clock = 1'b1;
                    w.last       = (i == FRAME_W - 1);
                    expected_pulses.push_back(w);
                end
            end
        end
    endfunction

    // Sample all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pulse_t want;
        if (!rst_n)
        begin
            mode = PROTO_PWM;
            expected_pulses.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (pulse.valid && pulse.ready)
            begin
                if (expected_pulses.size() == 0)
                    report_mismatch($sformatf("word for slot %0d with none expected",
                                              pulse.slot));
                else
                begin
                    want = expected_pulses.pop_front();
                    if (pulse.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  pulse.slot, want.slot));
                    if (pulse.high_ticks !== want.high_ticks)
                        report_mismatch($sformatf("slot %0d high_ticks %0d, expected %0d",
                                                  want.slot, pulse.high_ticks,
                                                  want.high_ticks));
                    if (pulse.low_ticks !== want.low_ticks)
                        report_mismatch($sformatf("slot %0d low_ticks %0d, expected %0d",
                                                  want.slot, pulse.low_ticks,
                                                  want.low_ticks));
                    if (pulse.fast_clock !== want.fast_clock)
                        report_mismatch($sformatf("slot %0d fast_clock %b, expected %b",
                                                  want.slot, pulse.fast_clock,
                                                  want.fast_clock));
                    if (pulse.last !== want.last)
                        report_mismatch($sformatf("slot %0d last %b, expected %b",
                                                  want.slot, pulse.last, want.last));
                end
            end
            if (cmd.valid && cmd.ready)
                encode_throttle(mode, cmd.throttle, cmd.telemetry_request);
            if (cfg.valid && cfg.ready)
                mode = protocol_t'(cfg.data);
            outstanding = expected_pulses.size();
        end
    end

endmodule

/* test/esc_throttle_pulse_encoder_tb.sv */
// Testbench top for the ESC throttle pulse encoder: clock, reset, command
// and protocol stimulus, output back-pressure, and the final verdict.
// Depends on etpe_pkg, etpe_if.sv, the encoder and its checker module.
`timescale 1ns / 100ps

module esc_throttle_pulse_encoder_tb;
    import etpe_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   words_sent;
    int   words_taken;
    logic tx_calm;
    logic rx_calm;

    etpe_cfg_if   cfg_ch ();
    etpe_cmd_if   cmd_ch ();
    etpe_pulse_if pulse_ch ();

    esc_throttle_pulse_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .pulse (pulse_ch)
    );

    esc_throttle_pulse_encoder_checker u_pulse_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .cmd         (cmd_ch),
        .pulse       (pulse_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("esc_throttle_pulse_encoder test failed");
        $finish;
    end

    // Sends one command word after a random gap; valid stays high afterwards.
    task automatic send_command(input logic [THROTTLE_W-1:0] throttle,
                                input logic telemetry);
        int gap;
        begin
            if (words_sent % 12 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            gap = tx_calm ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cmd_ch.valid             <= 1'b1;
            cmd_ch.throttle          <= throttle;
            cmd_ch.telemetry_request <= telemetry;
            do
                @(posedge clk);
            while (!cmd_ch.ready);
            words_sent++;
        end
    endtask

    // Holds the command side until every predicted pulse word has come out.
    task automatic wait_for_pulses();
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
            while (outstanding != 0)
                @(negedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // Writes the protocol register once the block is idle.
    task automatic set_protocol(input protocol_t proto);
        begin
            wait_for_pulses();
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= proto;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            cfg_ch.valid <= 1'b0;
        end
    endtask

    // Throttle values biased towards the extremes and the Multishot knee.
    function automatic logic [THROTTLE_W-1:0] pick_throttle();
        begin
            case ($urandom_range(0, 7))
                0:       return $urandom_range(0, 1) ? 11'h7FF : 11'h000;
                1:       return THROTTLE_W'($urandom_range(990, 1010));
                default: return THROTTLE_W'($urandom_range(0, 2047));
            endcase
        end
    endfunction

    // Output side: a random stall before each word, with calm stretches.
    initial
    begin
        int stall;
        pulse_ch.ready = 1'b0;
        words_taken = 0;
        rx_calm = 1'b0;
        repeat (12) @(posedge clk);
        forever
        begin
            if (words_taken % 10 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                pulse_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pulse_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pulse_ch.valid);
            words_taken++;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int        items_left;
        int        count;
        int        guard;
        protocol_t proto;

        rst_n                    = 1'b0;
        cmd_ch.valid             = 1'b0;
        cmd_ch.throttle          = '0;
        cmd_ch.telemetry_request = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.data              = '0;
        words_sent               = 0;
        tx_calm                  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words; PWM first, straight from reset.
        send_command(11'h000, 1'b0);
        send_command(11'h7FF, 1'b1);
        set_protocol(PROTO_ONESHOT125);
        send_command(11'h7FF, 1'b1);
        send_command(11'h001, 1'b0);
        set_protocol(PROTO_ONESHOT42);
        send_command(11'h000, 1'b1);
        send_command(11'h7FF, 1'b0);
        send_command(11'd1000, 1'b0);
        // Multishot below, at and above the saturation point.
        set_protocol(PROTO_MULTISHOT);
        send_command(11'h000, 1'b0);
        send_command(11'd999, 1'b1);
        send_command(11'd1000, 1'b0);
        send_command(11'd1001, 1'b0);
        send_command(11'h7FF, 1'b1);
        set_protocol(PROTO_DSHOT150);
        send_command(11'h000, 1'b1);
        send_command(11'h7FF, 1'b0);
        set_protocol(PROTO_DSHOT300);
        send_command(11'h555, 1'b0);
        send_command(11'h2AA, 1'b1);
        set_protocol(PROTO_DSHOT600);
        send_command(11'h7FF, 1'b1);
        send_command(11'h000, 1'b0);
        set_protocol(PROTO_DSHOT1200);
        send_command(11'h7FF, 1'b1);
        send_command(11'h0F0, 1'b0);

        // Random phases: every protocol in turn, then random ones.
        items_left = 210;
        for (int phase = 0; items_left > 0; phase++)
        begin
            proto = (phase < 8) ? protocol_t'(phase) : protocol_t'($urandom_range(0, 7));
            set_protocol(proto);
            count = $urandom_range(12, 22);
            if (count > items_left)
                count = items_left;
            for (int k = 0; k < count; k++)
            begin
                // Let the output drain completely now and then.
                if ((phase == 0 && k == 8) || $urandom_range(0, 29) == 0)
                    wait_for_pulses();
                send_command(pick_throttle(), 1'($urandom_range(0, 1)));
            end
            items_left -= count;
        end

        // Drain, then give the pipeline time to show any stray word.
        cmd_ch.valid <= 1'b0;
        guard = 0;
        @(negedge clk);
        while (outstanding != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("esc_throttle_pulse_encoder test passed");
        else
            $display("esc_throttle_pulse_encoder test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/etpe_pkg.sv
rtl/core/etpe_if.sv
rtl/core/esc_throttle_pulse_encoder.sv
test/esc_throttle_pulse_encoder_checker.sv
test/esc_throttle_pulse_encoder_tb.sv
